// ===== src/nfcrd_pkg.sv =====
package nfcrd_pkg;

   // Start pair bytes
   localparam logic [7:0] PREAMBLE_ZERO = 8'h00;
   localparam logic [7:0] START_MARKER  = 8'hFF;

   // Configuration register indexes
   localparam logic [0:0] CSR_RESPONSE_TFI = 1'd0;
   localparam logic [0:0] CSR_ERROR_TFI    = 1'd1;

   localparam logic [7:0] RESPONSE_TFI_RESET = 8'd213;
   localparam logic [7:0] ERROR_TFI_RESET    = 8'd127;

   // Output item depth of the result queue
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LEN,
      PH_LCS,
      PH_BODY,
      PH_BAD
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_LOSS  = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      status_type status_code;
      logic [7:0] payload_count;
      logic       last_item;
   } rsp_item_type;

endpackage

// ===== src/nfc_response_frame_deframer_top.sv =====
// Channel | Dir | Handshake            | Payload
// req     | in  | req_tvalid/tready    | tdata: data_byte, expected_cmd; tlast: buffer_end
// rsp     | out | rsp_tvalid/tready    | tdata: payload_byte, status_code, payload_count;
//         |     |                      | tuser: item_kind; tlast: last_item
// csr     | in  | csr_valid/csr_ready  | csr_index, csr_data (always ready)
//
// One byte per cycle while req_tready is high: the parser updates its state in
// the cycle a byte is taken and pushes zero, one or two result transactions into a
// 4-entry queue; results leave one per cycle from its head while rsp_tready is high.
// req_tready drops only when the queue holds three or more results, which takes a
// stalled rsp consumer; a buffer-end byte that is also a payload byte makes two.
// Reset (synchronous, active high) clears frame state and queue, TFIs to 213/127.
module nfc_response_frame_deframer_top (
   input  logic                      clock,
   input  logic                      reset,
   // [7:0] data_byte, [15:8] expected_cmd
   input  logic [15:0]               req_tdata,
   input  logic                      req_tlast,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // [7:0] payload_byte, [9:8] status_code, [17:10] payload_count, [23:18] zero
   output logic [23:0]               rsp_tdata,
   // [0] item_kind
   output logic                      rsp_tuser,
   output logic                      rsp_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [0:0]                csr_index,
   input  logic [7:0]                csr_data
);
   import nfcrd_pkg::*;

   // Configuration registers
   logic [7:0] response_tfi_ff;
   logic [7:0] error_tfi_ff;

   // Frame state
   phase_type  phase_ff, phase_in;
   logic       prev_zero_ff, prev_zero_in;
   logic [7:0] len_ff, len_in;
   logic [8:0] idx_ff, idx_in;        // bytes seen after LCS
   logic [7:0] sum_ff, sum_in;
   status_type verdict_ff, verdict_in; // header verdict
   logic       lcs_good_ff, lcs_good_in;

   // Result queue
   rsp_item_type        queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;

   logic         accept;
   logic [7:0]   din;
   logic [8:0]   want_cmd;
   logic [8:0]   target;
   logic         lcs_sum_zero;
   logic         emit_payload;
   rsp_item_type pay_item, stat_item, item0, item1;
   logic [1:0]   num_wr;
   logic         pop;
   status_type   final_status;
   logic [7:0]   final_count;

   assign csr_ready = 1'b1;
   assign accept    = req_tvalid && req_tready;
   assign pop       = rsp_tvalid && rsp_tready;
   assign din       = req_tdata[7:0];
   assign want_cmd  = {1'b0, req_tdata[15:8]} + 9'd1;
   assign target    = {1'b0, len_ff} + 9'd2;
   assign lcs_sum_zero = (len_ff + din) == 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         response_tfi_ff <= RESPONSE_TFI_RESET;
         error_tfi_ff    <= ERROR_TFI_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RESPONSE_TFI: response_tfi_ff <= csr_data;
            CSR_ERROR_TFI:    error_tfi_ff    <= csr_data;
            default:          ;
         endcase
      end
   end

   // Per-byte parse step
   always_comb begin
      phase_in     = phase_ff;
      prev_zero_in = prev_zero_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      verdict_in   = verdict_ff;
      lcs_good_in  = lcs_good_ff;
      emit_payload = 1'b0;

      unique case (phase_ff)
         PH_HUNT: begin
            if (prev_zero_ff && din == START_MARKER) begin
               phase_in = PH_LEN;
            end
            prev_zero_in = (din == PREAMBLE_ZERO);
         end
         PH_LEN: begin
            len_in   = din;
            phase_in = PH_LCS;
         end
         PH_LCS: begin
            lcs_good_in = lcs_sum_zero;
            phase_in    = lcs_sum_zero ? PH_BODY : PH_BAD;
         end
         PH_BODY: begin
            if (idx_ff < target) begin
               if (idx_ff <= {1'b0, len_ff}) begin
                  sum_in = sum_ff + din;
               end
               if (idx_ff == 9'd0) begin
                  // TFI
                  if (din == error_tfi_ff) begin
                     verdict_in = STATUS_ERROR;
                  end else if (din != response_tfi_ff) begin
                     verdict_in = STATUS_LOSS;
                  end
               end else if (idx_ff == 9'd1) begin
                  // CMD
                  if (verdict_ff == STATUS_OK &&
                      (len_ff < 8'd2 || {1'b0, din} != want_cmd)) begin
                     verdict_in = STATUS_LOSS;
                  end
               end else if (idx_ff < {1'b0, len_ff} && verdict_ff == STATUS_OK) begin
                  emit_payload = 1'b1;
               end
               idx_in = idx_ff + 9'd1;
            end
         end
         PH_BAD: ;
         default: ;
      endcase

      // Final status; truncation wins over the header verdicts
      final_count = 8'd0;
      if (phase_in != PH_BODY || !lcs_good_in || idx_in < target) begin
         final_status = STATUS_LOSS;
      end else if (verdict_in != STATUS_OK) begin
         final_status = verdict_in;
      end else if (sum_in != 8'd0) begin
         final_status = STATUS_LOSS;
      end else begin
         final_status = STATUS_OK;
         final_count  = len_in - 8'd2;
      end

      if (req_tlast) begin
         phase_in     = PH_HUNT;
         prev_zero_in = 1'b0;
         len_in       = 8'd0;
         idx_in       = 9'd0;
         sum_in       = 8'd0;
         verdict_in   = STATUS_OK;
         lcs_good_in  = 1'b0;
      end

      pay_item = '{kind: KIND_PAYLOAD, payload_byte: din, status_code: STATUS_OK,
                   payload_count: 8'd0, last_item: 1'b0};
      stat_item = '{kind: KIND_STATUS, payload_byte: 8'd0, status_code: final_status,
                    payload_count: final_count, last_item: 1'b1};

      item0  = emit_payload ? pay_item : stat_item;
      item1  = stat_item;
      num_wr = {1'b0, emit_payload} + {1'b0, req_tlast};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         prev_zero_ff <= 1'b0;
         len_ff       <= 8'd0;
         idx_ff       <= 9'd0;
         sum_ff       <= 8'd0;
         verdict_ff   <= STATUS_OK;
         lcs_good_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         prev_zero_ff <= prev_zero_in;
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         verdict_ff   <= verdict_in;
         lcs_good_ff  <= lcs_good_in;
      end
   end

   // Result queue: up to two pushes, one pop per cycle
   always_ff @(posedge clock) begin
      if (accept && num_wr != 2'd0) begin
         queue_ff[wr_ptr_ff] <= item0;
      end
      if (accept && num_wr == 2'd2) begin
         queue_ff[wr_ptr_ff + QPTR_W'(1)] <= item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(num_wr);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_ff + (accept ? (QPTR_W+1)'(num_wr) : '0)
                     - (QPTR_W+1)'(pop);
      end
   end

   assign req_tready = count_ff <= (QPTR_W+1)'(QUEUE_DEPTH - 2);
   assign rsp_tvalid = count_ff != '0;

   rsp_item_type head;
   assign head      = queue_ff[rd_ptr_ff];
   assign rsp_tdata = {6'd0, head.payload_count, head.status_code, head.payload_byte};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last_item;

endmodule

// ===== src/nfcrd_checker.sv =====
module nfcrd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready
);

   // Status transactions, and only they, close a run
   a_kind_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == rsp_tlast))
      else $error("item kind and last flag disagree");

   // Payload transactions carry no status and no count
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[23:8] == 16'd0)
      else $error("payload item with status or count bits");

   // Non-ok status has no count, and the status code is never 3
   a_status_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         rsp_tdata[9:8] != 2'd3 && rsp_tdata[7:0] == 8'd0 &&
         (rsp_tdata[9:8] == 2'd0 || rsp_tdata[17:10] == 8'd0))
      else $error("malformed status item");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
         $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Input backpressure only while results are waiting
   a_req_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req_tready low with an empty result queue");

endmodule

bind nfc_response_frame_deframer_top nfcrd_checker u_nfcrd_checker (.*);
